FILE: design/hunt_bisection_bracket_search_macros.svh
// ----------------------------------------------------------------------------
// hunt_bisection_bracket_search_macros.svh
// Assertion shorthands for the bracket search; clocked on i_clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef HUNT_BISECTION_BRACKET_SEARCH_MACROS_SVH
`define HUNT_BISECTION_BRACKET_SEARCH_MACROS_SVH

// Check in the same cycle as the antecedent.
`define HBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check in the cycle after the antecedent.
`define HBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/hbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_pkg
// Sizes, microcode field codes and the control store of the bracket search.
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_W       = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = IDX_W + 1;
    localparam int INC2_W      = LEN_W + 1;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(TABLE_DEPTH);

    // Program counter and step addresses
    typedef logic [3:0] t_upc;
    localparam t_upc PC_IDLE = 4'd0;
    localparam t_upc PC_KEY0 = 4'd1;
    localparam t_upc PC_DIR  = 4'd2;
    localparam t_upc PC_HUNT = 4'd3;
    localparam t_upc PC_UP   = 4'd4;
    localparam t_upc PC_DN   = 4'd5;
    localparam t_upc PC_BIS  = 4'd6;
    localparam t_upc PC_BCHK = 4'd7;
    localparam t_upc PC_EMIT = 4'd8;

    // Datapath operation
    typedef enum logic [3:0] {
        OP_LOAD  = 4'd0,
        OP_KEY0  = 4'd1,
        OP_DIR   = 4'd2,
        OP_H0    = 4'd3,
        OP_UP    = 4'd4,
        OP_DN    = 4'd5,
        OP_MID   = 4'd6,
        OP_BSTEP = 4'd7,
        OP_EMIT  = 4'd8
    } t_uop;

    // Table read address source
    typedef enum logic [2:0] {
        A_ZERO  = 3'd0,
        A_LAST  = 3'd1,
        A_GUESS = 3'd2,
        A_HUNT  = 3'd3,
        A_HI    = 3'd4,
        A_LO    = 3'd5,
        A_MID   = 3'd6
    } t_asel;

    // Jump condition
    typedef enum logic [3:0] {
        C_ALWAYS  = 4'd0,
        C_START   = 4'd1,
        C_TRIV    = 4'd2,
        C_NOTLOW  = 4'd3,
        C_UPGO    = 4'd4,
        C_DNGO    = 4'd5,
        C_SPAN    = 4'd6,
        C_SPANNX  = 4'd7,
        C_OUTFREE = 4'd8
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_asel asel;
        t_cond cond;
        t_upc  jt;   // next step when the condition holds
        t_upc  jf;   // next step otherwise
    } t_uword;

    function automatic t_uword uc_rom(input t_upc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE: w = '{OP_LOAD,  A_ZERO,  C_START,   PC_KEY0, PC_IDLE};
            PC_KEY0: w = '{OP_KEY0,  A_LAST,  C_ALWAYS,  PC_DIR,  PC_DIR };
            PC_DIR:  w = '{OP_DIR,   A_GUESS, C_TRIV,    PC_BIS,  PC_HUNT};
            PC_HUNT: w = '{OP_H0,    A_HUNT,  C_NOTLOW,  PC_DN,   PC_UP  };
            PC_UP:   w = '{OP_UP,    A_HI,    C_UPGO,    PC_UP,   PC_BIS };
            PC_DN:   w = '{OP_DN,    A_LO,    C_DNGO,    PC_DN,   PC_BIS };
            PC_BIS:  w = '{OP_MID,   A_MID,   C_SPAN,    PC_BCHK, PC_EMIT};
            PC_BCHK: w = '{OP_BSTEP, A_MID,   C_SPANNX,  PC_BCHK, PC_EMIT};
            PC_EMIT: w = '{OP_EMIT,  A_ZERO,  C_OUTFREE, PC_IDLE, PC_EMIT};
            default: w = '{OP_EMIT,  A_ZERO,  C_ALWAYS,  PC_IDLE, PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: design/hbs_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_ifs
// Valid/ready channels of the bracket search: input items and results.
// ----------------------------------------------------------------------------
interface hbs_in_if import hbs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [IDX_W-1:0]        entry_index;
    logic signed [KEY_W-1:0] entry_value;
    logic signed [KEY_W-1:0] query_value;
    logic [IDX_W-1:0]        guess_index;

    modport source (output valid, kind, entry_index, entry_value, query_value,
                    guess_index, input ready);
    modport sink   (input valid, kind, entry_index, entry_value, query_value,
                    guess_index, output ready);
endinterface

interface hbs_out_if import hbs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] bracket_low;

    modport source (output valid, bracket_low, input ready);
    modport sink   (input valid, bracket_low, output ready);
endinterface

FILE: design/hunt_bisection_bracket_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hunt_bisection_bracket_search
// Hunt-and-bisection search over a monotonic table of signed Q16.16 keys.
// ----------------------------------------------------------------------------
// A write item (kind 0) stores one key and is taken at idle, giving no
// result. A query item (kind 1) returns the lower index of the table interval
// that brackets query_value, clamped to 0 or table_length-1 outside the table;
// ties sit on the low side (>= for ascending tables, <= for descending ones),
// and the table counts as ascending when its last key exceeds its first. A
// guess of 0 or at/beyond table_length bisects the whole table; any other
// guess hunts outward with doubling steps, then bisects. Each probe is one
// read of the single key memory, and the sequencer issues one probe per
// cycle; a query runs set-up steps that load it, store the first key and
// set the direction, then the hunt probes, a bisection entry step, the
// bisection probes and a step that hands the result over. Only one item is
// in work at a time; the next item is taken as soon as the result sits in
// the output register, even while that result still waits for its
// transfer. Write table_length only while the block is idle. The key
// memory is not cleared: every entry below table_length must be written
// before a query reads it.
// ----------------------------------------------------------------------------
`include "hunt_bisection_bracket_search_macros.svh"

module hunt_bisection_bracket_search import hbs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hbs_in_if.sink           i_item,
    hbs_out_if.source        o_res,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata
);

    // ---------------------------------------------------------------- state
    logic [LEN_W-1:0]        r_len;
    t_upc                    r_pc;
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_bracket;

    logic signed [KEY_W-1:0] r_val;
    logic [IDX_W-1:0]        r_guess;
    logic [LEN_W-1:0]        r_n;
    logic signed [KEY_W-1:0] r_key0;
    logic                    r_ascend;
    logic [LEN_W-1:0]        r_lo;
    logic [LEN_W-1:0]        r_hi;
    logic [LEN_W-1:0]        r_inc;
    logic [LEN_W-1:0]        r_mid;

    logic [KEY_W-1:0]        r_mem [TABLE_DEPTH];
    logic signed [KEY_W-1:0] r_rdata;

    logic [LEN_W-1:0]        n_lo;
    logic [LEN_W-1:0]        n_hi;
    logic [LEN_W-1:0]        n_inc;
    logic [LEN_W-1:0]        n_mid;

    t_uword                  uw;
    logic                    accept;
    logic                    wr_en;
    logic                    start;
    logic                    out_free;
    logic                    low;
    logic                    triv;
    logic                    hi_at_end;
    logic [INC2_W-1:0]       inc2;
    logic [LEN_W-1:0]        up_room;
    logic                    up_ovf;
    logic                    dn_ovf;
    logic [LEN_W-1:0]        up_sum;
    logic [LEN_W-1:0]        dn_dif;
    logic [LEN_W:0]          mid_sum;
    logic [LEN_W-1:0]        span_now;
    logic [LEN_W-1:0]        span_nx;
    logic [LEN_W-1:0]        n_eff;
    logic [IDX_W-1:0]        raddr;
    logic                    jump;

    // ---------------------------------------------------------- handshakes
    assign uw          = uc_rom(r_pc);
    assign i_item.ready = (r_pc == PC_IDLE);
    assign accept      = i_item.valid && i_item.ready;
    assign wr_en       = accept && !i_item.kind;
    assign start       = accept && i_item.kind;
    assign out_free    = !r_out_valid || o_res.ready;

    assign o_res.valid       = r_out_valid;
    assign o_res.bracket_low = r_bracket;

    // Clamp the programmed length into 1..TABLE_DEPTH
    always_comb begin
        priority if (r_len == '0) begin
            n_eff = LEN_W'(1);
        end else if (r_len > LEN_W'(TABLE_DEPTH)) begin
            n_eff = LEN_W'(TABLE_DEPTH);
        end else begin
            n_eff = r_len;
        end
    end

    // --------------------------------------------------------- comparisons
    // Keys compare as signed words; the probed key is the registered read.
    assign low       = r_ascend ? (r_val >= r_rdata) : (r_val <= r_rdata);
    assign triv      = (r_guess == '0) || ({1'b0, r_guess} >= r_n);
    assign hi_at_end = (r_hi == r_n);
    assign inc2      = {r_inc, 1'b0};
    assign up_room   = r_n - r_hi;
    assign up_ovf    = inc2 >= {1'b0, up_room};
    assign dn_ovf    = inc2 >= {1'b0, r_lo};
    assign up_sum    = r_hi + inc2[LEN_W-1:0];
    assign dn_dif    = r_lo - inc2[LEN_W-1:0];

    // ---------------------------------------------------- bracket datapath
    always_comb begin
        n_lo  = r_lo;
        n_hi  = r_hi;
        n_inc = r_inc;
        unique case (uw.op)
            OP_DIR: begin
                n_inc = LEN_W'(1);
                if (triv) begin
                    n_lo = '0;
                    n_hi = r_n;
                end else begin
                    n_lo = {1'b0, r_guess};
                end
            end
            OP_H0: begin
                // step one place towards the value; a guess at the last
                // entry on the low side leaves hi at the length
                if (low) begin
                    n_hi = r_lo + LEN_W'(1);
                end else begin
                    n_hi = r_lo;
                    n_lo = r_lo - LEN_W'(1);
                end
            end
            OP_UP: begin
                if (!hi_at_end && low) begin
                    n_lo  = r_hi;
                    n_inc = inc2[LEN_W-1:0];
                    n_hi  = up_ovf ? r_n : up_sum;
                end
            end
            OP_DN: begin
                if (!low) begin
                    n_hi  = r_lo;
                    n_inc = inc2[LEN_W-1:0];
                    n_lo  = dn_ovf ? '0 : dn_dif;
                end
            end
            OP_BSTEP: begin
                if (low) begin
                    n_lo = r_mid;
                end else begin
                    n_hi = r_mid;
                end
            end
            OP_LOAD, OP_KEY0, OP_MID, OP_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    assign mid_sum  = {1'b0, n_lo} + {1'b0, n_hi};
    assign n_mid    = mid_sum[LEN_W:1];
    assign span_now = r_hi - r_lo;
    assign span_nx  = n_hi - n_lo;

    // Read address for the probe used by the next step
    always_comb begin
        unique case (uw.asel)
            A_ZERO:  raddr = '0;
            A_LAST:  raddr = IDX_W'(r_n - LEN_W'(1));
            A_GUESS: raddr = r_guess;
            A_HUNT:  raddr = low ? n_hi[IDX_W-1:0] : n_lo[IDX_W-1:0];
            A_HI:    raddr = n_hi[IDX_W-1:0];
            A_LO:    raddr = n_lo[IDX_W-1:0];
            A_MID:   raddr = n_mid[IDX_W-1:0];
            default: raddr = '0;
        endcase
    end

    // ------------------------------------------------------ jump condition
    always_comb begin
        unique case (uw.cond)
            C_ALWAYS:  jump = 1'b1;
            C_START:   jump = start;
            C_TRIV:    jump = triv;
            C_NOTLOW:  jump = !low;
            C_UPGO:    jump = !hi_at_end && low && !up_ovf;
            C_DNGO:    jump = !low && !dn_ovf;
            C_SPAN:    jump = span_now > LEN_W'(1);
            C_SPANNX:  jump = span_nx > LEN_W'(1);
            C_OUTFREE: jump = out_free;
            default:   jump = 1'b0;
        endcase
    end

    // ------------------------------------------------------ control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_RESET;
            r_pc        <= PC_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            r_pc <= jump ? uw.jt : uw.jf;
            // load the result when the slot is free, else drop it after transfer
            if (uw.op == OP_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------- payload registers
    always_ff @(posedge i_clk) begin
        // hold the query operands while the sequencer is away from idle
        if (uw.op == OP_LOAD) begin
            r_val   <= i_item.query_value;
            r_guess <= i_item.guess_index;
            r_n     <= n_eff;
        end
        if (uw.op == OP_KEY0) begin
            r_key0 <= r_rdata;
        end
        if (uw.op == OP_DIR) begin
            r_ascend <= r_rdata > r_key0;
        end
        if (uw.op == OP_EMIT && out_free) begin
            r_bracket <= r_lo[IDX_W-1:0];
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_inc <= n_inc;
        r_mid <= n_mid;
    end

    // ----------------------------------------------------------- key memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_item.entry_index] <= i_item.entry_value;
        end
        r_rdata <= r_mem[raddr];
    end

    // ----------------------------------------------------------- assertions
    // A downward hunt that passes below entry 0 clamps the bracket's low end to 0.
    `HBS_ASSERT_NEXT(a_query_starts, start, r_pc == PC_KEY0,
        "accepted query did not start the program")
    `HBS_ASSERT_NOW(a_bracket_order,
        r_pc == PC_UP || r_pc == PC_DN || r_pc == PC_BIS || r_pc == PC_BCHK,
        r_lo <= r_hi && r_hi <= r_n, "bracket bounds out of order")
    `HBS_ASSERT_NOW(a_emit_in_range, r_pc == PC_EMIT, r_lo < r_n,
        "bracket index at or beyond the table length")
    `HBS_ASSERT_NEXT(a_result_loaded, r_pc == PC_EMIT && out_free,
        o_res.valid && o_res.bracket_low == $past(r_lo[IDX_W-1:0]),
        "result register not loaded from the bracket")

endmodule
